// ===== rtl/core/sobel_gradient_magnitude_macros.svh =====
// ----------------------------------------------------------------------------
// Sobel gradient magnitude - assertion macros
// Shorthand for the clocked checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SOBEL_GRADIENT_MAGNITUDE_MACROS_SVH
`define SOBEL_GRADIENT_MAGNITUDE_MACROS_SVH

// Check a consequence in the same cycle as its trigger
`define SGM_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger
`define SGM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sgm_pkg.sv =====
// ----------------------------------------------------------------------------
// Sobel gradient magnitude - shared definitions
// Field widths, register indexes and the types passed between the stages.
// ----------------------------------------------------------------------------
package sgm_pkg;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int GRAD_W     = 8;
    localparam int ROW_W      = 12;
    localparam int CCOL_W     = 10;
    localparam int H_W        = 13;
    localparam int IW_CFG_W   = 11;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    // Size limits and reset values
    localparam int MAX_WIDTH_DEF     = 1024;
    localparam int MIN_DIM           = 3;
    localparam int HEIGHT_LIMIT      = 4096;
    localparam int IMAGE_WIDTH_RESET = 1024;
    localparam int IMAGE_HEIGHT_RST  = 768;
    localparam int QUEUE_DEPTH_DEF   = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // One 3x3 neighbourhood, indexed [row][col], plus its position
    typedef struct packed {
        logic [2:0][2:0][PIX_W-1:0] win;
        logic [ROW_W-1:0]           centre_row;
        logic [CCOL_W-1:0]          centre_col;
        logic                       last;
    } win_item_t;

    // Queue fill status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
        logic nearly_full;
    } q_stat_t;

endpackage

// ===== rtl/core/sgm_pixel_if.sv =====
// ----------------------------------------------------------------------------
// Sobel gradient magnitude - pixel stream interface
// Raster pixels with a frame start mark, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sgm_pixel_if;
    import sgm_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

// ===== rtl/core/sgm_result_if.sv =====
// ----------------------------------------------------------------------------
// Sobel gradient magnitude - result stream interface
// Gradients, norm and centre position, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sgm_result_if;
    import sgm_pkg::*;

    logic              valid;
    logic              ready;
    logic [GRAD_W-1:0] grad_x;
    logic [GRAD_W-1:0] grad_y;
    logic [GRAD_W-1:0] grad_norm;
    logic [ROW_W-1:0]  centre_row;
    logic [CCOL_W-1:0] centre_col;
    logic              last;

    modport source (output valid, output grad_x, output grad_y, output grad_norm,
                    output centre_row, output centre_col, output last, input ready);
    modport sink   (input valid, input grad_x, input grad_y, input grad_norm,
                    input centre_row, input centre_col, input last, output ready);
endinterface

// ===== rtl/core/sgm_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Sobel gradient magnitude - configuration write interface
// Register index and write data, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sgm_cfg_if;
    import sgm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/sgm_front.sv =====
// ----------------------------------------------------------------------------
// Sobel gradient magnitude - front end
// Tracks the raster position, keeps the two line stores and the 3x3 window,
// and queues a neighbourhood for every interior centre.
// ----------------------------------------------------------------------------
module sgm_front #(
    parameter int MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    sgm_cfg_if.sink            cfg,
    sgm_pixel_if.sink          pixels,
    input  sgm_pkg::q_stat_t   q_stat,
    output logic               push,
    output sgm_pkg::win_item_t push_item
);
    import sgm_pkg::*;

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = $clog2(MAX_WIDTH + 1);
    localparam int CFG_EXT_W = (WID_W > IW_CFG_W) ? WID_W : IW_CFG_W;
    localparam int LINE_W    = 2 * PIX_W;
    localparam int W_RESET   = (MAX_WIDTH < IMAGE_WIDTH_RESET) ? MAX_WIDTH
                                                               : IMAGE_WIDTH_RESET;

    // Effective frame size, clamped on write
    logic [WID_W-1:0] w_eff_reg;
    logic [H_W-1:0]   h_eff_reg;
    logic [WID_W-1:0] w_clamped;
    logic [H_W-1:0]   h_clamped;
    logic [CFG_EXT_W-1:0] w_raw;
    logic [H_W-1:0]   h_raw;

    // Position of the next pixel
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] r_cur;
    logic [COL_W-1:0] c_cur;
    logic [WID_W-1:0] c_ext, c_inc;
    logic [H_W-1:0]   r_ext, r_inc;
    logic             interior_now, last_now;
    logic             accept;

    // Line store clearing after reset
    logic             clear_reg;
    logic [COL_W-1:0] clear_addr_reg;

    // Line store, upper line in the high byte
    logic [LINE_W-1:0] line_mem [MAX_WIDTH];
    logic [LINE_W-1:0] rd_data_reg;
    logic              bypass_reg;
    logic [LINE_W-1:0] bypass_data_reg;
    logic              mem_we;
    logic [COL_W-1:0]  mem_waddr;
    logic [LINE_W-1:0] mem_wdata;
    logic [LINE_W-1:0] line_rd;

    // Second stage: pixel whose line data is being read
    logic              pipe_valid_reg;
    logic [PIX_W-1:0]  pipe_px_reg;
    logic [COL_W-1:0]  pipe_col_reg;
    logic              pipe_interior_reg;
    logic              pipe_last_reg;
    logic [ROW_W-1:0]  pipe_crow_reg;
    logic [CCOL_W-1:0] pipe_ccol_reg;

    // Window, indexed [row][col]
    logic [2:0][2:0][PIX_W-1:0] win_reg, win_next;
    logic [PIX_W-1:0] top_px, mid_px;

    // Configuration is always taken
    assign cfg.ready = 1'b1;

    // Clamp incoming sizes
    always_comb
    begin
        w_raw = CFG_EXT_W'(cfg.data[IW_CFG_W-1:0]);
        if (w_raw < CFG_EXT_W'(MIN_DIM))
        begin
            w_clamped = WID_W'(MIN_DIM);
        end
        else if (w_raw > CFG_EXT_W'(MAX_WIDTH))
        begin
            w_clamped = WID_W'(MAX_WIDTH);
        end
        else
        begin
            w_clamped = WID_W'(w_raw);
        end
        h_raw = cfg.data[H_W-1:0];
        if (h_raw < H_W'(MIN_DIM))
        begin
            h_clamped = H_W'(MIN_DIM);
        end
        else if (h_raw > H_W'(HEIGHT_LIMIT))
        begin
            h_clamped = H_W'(HEIGHT_LIMIT);
        end
        else
        begin
            h_clamped = h_raw;
        end
    end

    // Size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_eff_reg <= WID_W'(W_RESET);
            h_eff_reg <= H_W'(IMAGE_HEIGHT_RST);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_IMAGE_WIDTH:  w_eff_reg <= w_clamped;
                REG_IMAGE_HEIGHT: h_eff_reg <= h_clamped;
                default:          ;
            endcase
        end
    end

    // Hold off input while clearing and while the queue could overflow
    assign pixels.ready = !clear_reg
                          && !(pipe_valid_reg ? (q_stat.nearly_full || q_stat.full)
                                              : q_stat.full);
    assign accept = pixels.valid && pixels.ready;

    // Classify the incoming pixel and advance the position
    always_comb
    begin
        r_cur = pixels.frame_start ? '0 : row_reg;
        c_cur = pixels.frame_start ? '0 : col_reg;
        c_ext = WID_W'(c_cur);
        r_ext = H_W'(r_cur);
        c_inc = c_ext + WID_W'(1);
        r_inc = r_ext + H_W'(1);
        interior_now = (r_ext >= H_W'(2)) && (r_ext < h_eff_reg)
                       && (c_ext >= WID_W'(2)) && (c_ext < w_eff_reg);
        last_now = (r_ext == h_eff_reg - H_W'(1)) && (c_ext == w_eff_reg - WID_W'(1));
        if (c_inc >= w_eff_reg)
        begin
            col_next = '0;
            row_next = (r_inc >= h_eff_reg) ? '0 : r_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = c_inc[COL_W-1:0];
            row_next = r_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // Sweep the line store to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg      <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clear_reg)
        begin
            if (clear_addr_reg == COL_W'(MAX_WIDTH - 1))
            begin
                clear_reg <= 1'b0;
            end
            clear_addr_reg <= clear_addr_reg + COL_W'(1);
        end
    end

    // Line data of the second stage, forwarded when just written
    assign line_rd = bypass_reg ? bypass_data_reg : rd_data_reg;
    assign top_px  = line_rd[LINE_W-1:PIX_W];
    assign mid_px  = line_rd[PIX_W-1:0];

    // Write port: clearing pass or the line shift of the second stage
    always_comb
    begin
        mem_we    = clear_reg || pipe_valid_reg;
        mem_waddr = clear_reg ? clear_addr_reg : pipe_col_reg;
        mem_wdata = clear_reg ? '0 : {mid_px, pipe_px_reg};
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rd_data_reg <= line_mem[c_cur];
        end
    end

    // Forward a write to the address read in the same cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bypass_reg      <= pipe_valid_reg && (c_cur == pipe_col_reg);
            bypass_data_reg <= {mid_px, pipe_px_reg};
        end
    end

    // Second stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg <= 1'b0;
        end
        else
        begin
            pipe_valid_reg <= accept;
        end
    end

    // Second stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pipe_px_reg       <= pixels.pixel;
            pipe_col_reg      <= c_cur;
            pipe_interior_reg <= interior_now;
            pipe_last_reg     <= last_now;
            pipe_crow_reg     <= r_cur - ROW_W'(1);
            pipe_ccol_reg     <= CCOL_W'(c_cur - COL_W'(1));
        end
    end

    // Shift the window by one column
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
        end
        win_next[0][2] = top_px;
        win_next[1][2] = mid_px;
        win_next[2][2] = pipe_px_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_valid_reg)
        begin
            win_reg <= win_next;
        end
    end

    // Queue interior centres
    assign push                 = pipe_valid_reg && pipe_interior_reg;
    assign push_item.win        = win_next;
    assign push_item.centre_row = pipe_crow_reg;
    assign push_item.centre_col = pipe_ccol_reg;
    assign push_item.last       = pipe_last_reg;

endmodule

// ===== rtl/core/sgm_queue.sv =====
// ----------------------------------------------------------------------------
// Sobel gradient magnitude - neighbourhood queue
// Short first-in first-out store between the front and back ends.
// ----------------------------------------------------------------------------
module sgm_queue #(
    parameter int DEPTH = sgm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sgm_pkg::win_item_t push_item,
    input  logic               pop,
    output sgm_pkg::win_item_t head,
    output sgm_pkg::q_stat_t   stat
);
    import sgm_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    win_item_t         entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    // Status from the registered count
    assign stat.empty       = (count_reg == '0);
    assign stat.full        = (count_reg == CNT_W'(DEPTH));
    assign stat.nearly_full = (count_reg == CNT_W'(DEPTH - 1));
    assign head             = entry_reg[rd_ptr_reg];

    // Store on push
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/core/sgm_back.sv =====
// ----------------------------------------------------------------------------
// Sobel gradient magnitude - back end
// Kernel responses, squared sum and a pipelined digit-by-digit square root,
// ending in the output register.
// ----------------------------------------------------------------------------
module sgm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  sgm_pkg::win_item_t head,
    input  sgm_pkg::q_stat_t   stat,
    output logic               pop,
    sgm_result_if.source       results
);
    import sgm_pkg::*;

    localparam int ROOT_W    = GRAD_W + 1;
    localparam int SUM_W     = 2 * ROOT_W;
    localparam int REM_W     = ROOT_W + 1;
    localparam int KS_W      = PIX_W + 2;
    localparam int SQ_STEPS  = 3;
    localparam int SQ_STAGES = ROOT_W / SQ_STEPS;

    typedef struct packed {
        logic [GRAD_W-1:0] gx;
        logic [GRAD_W-1:0] gy;
        logic [ROW_W-1:0]  centre_row;
        logic [CCOL_W-1:0] centre_col;
        logic              last;
    } meta_t;

    typedef struct packed {
        logic [SUM_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_state_t;

    // One root digit: bring down two radicand bits and try a one
    function automatic sq_state_t sqrt_step(input sq_state_t s);
        logic [REM_W+1:0] acc;
        logic [REM_W+1:0] trial;
        sq_state_t        n;
        acc   = {s.rem, s.rad[SUM_W-1 -: 2]};
        trial = (REM_W + 2)'({s.root, 2'b01});
        n.rad = {s.rad[SUM_W-3:0], 2'b00};
        if (acc >= trial)
        begin
            n.rem  = REM_W'(acc - trial);
            n.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            n.rem  = REM_W'(acc);
            n.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return n;
    endfunction

    // Absolute difference of two kernel halves, quartered
    function automatic logic [GRAD_W-1:0] abs_quarter(input logic [KS_W-1:0] a,
                                                      input logic [KS_W-1:0] b);
        logic [KS_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return d[KS_W-1:2];
    endfunction

    logic advance;

    logic [KS_W-1:0] xp, xn, yp, yn;
    meta_t           g_next;

    logic        g_valid_reg;
    meta_t       g_meta_reg;
    logic        q_valid_reg;
    meta_t       q_meta_reg;
    logic [SUM_W-1:0] q_sum_reg;
    logic [2*GRAD_W-1:0] sqx, sqy;

    logic        s_valid_reg [SQ_STAGES];
    meta_t       s_meta_reg  [SQ_STAGES];
    sq_state_t   s_state_reg [SQ_STAGES];
    sq_state_t   s_in        [SQ_STAGES];
    sq_state_t   s_next      [SQ_STAGES];

    logic              out_valid_reg;
    meta_t             out_meta_reg;
    logic [GRAD_W-1:0] out_norm_reg;
    logic [ROOT_W-1:0] root_fin;

    // Move the whole pipeline while the output register can take a result
    assign advance = !out_valid_reg || results.ready;
    assign pop     = advance && !stat.empty;

    // Kernel halves of the horizontal and vertical responses
    always_comb
    begin
        xp = KS_W'(head.win[0][2]) + {1'b0, head.win[1][2], 1'b0} + KS_W'(head.win[2][2]);
        xn = KS_W'(head.win[0][0]) + {1'b0, head.win[1][0], 1'b0} + KS_W'(head.win[2][0]);
        yp = KS_W'(head.win[2][0]) + {1'b0, head.win[2][1], 1'b0} + KS_W'(head.win[2][2]);
        yn = KS_W'(head.win[0][0]) + {1'b0, head.win[0][1], 1'b0} + KS_W'(head.win[0][2]);
        g_next.gx         = abs_quarter(xp, xn);
        g_next.gy         = abs_quarter(yp, yn);
        g_next.centre_row = head.centre_row;
        g_next.centre_col = head.centre_col;
        g_next.last       = head.last;
    end

    // Squares of the two responses
    assign sqx = g_meta_reg.gx * g_meta_reg.gx;
    assign sqy = g_meta_reg.gy * g_meta_reg.gy;

    // Root digits, a few per stage
    always_comb
    begin
        s_in[0].rad  = q_sum_reg;
        s_in[0].rem  = '0;
        s_in[0].root = '0;
        for (int s = 1; s < SQ_STAGES; s++)
        begin
            s_in[s] = s_state_reg[s-1];
        end
        for (int s = 0; s < SQ_STAGES; s++)
        begin
            s_next[s] = s_in[s];
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                s_next[s] = sqrt_step(s_next[s]);
            end
        end
    end

    // Root from the last square-root stage, saturated to a byte in the output register
    assign root_fin = s_state_reg[SQ_STAGES-1].root;

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg   <= 1'b0;
            q_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < SQ_STAGES; s++)
            begin
                s_valid_reg[s] <= 1'b0;
            end
        end
        else if (advance)
        begin
            g_valid_reg    <= pop;
            q_valid_reg    <= g_valid_reg;
            s_valid_reg[0] <= q_valid_reg;
            for (int s = 1; s < SQ_STAGES; s++)
            begin
                s_valid_reg[s] <= s_valid_reg[s-1];
            end
            out_valid_reg <= s_valid_reg[SQ_STAGES-1];
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            g_meta_reg     <= g_next;
            q_meta_reg     <= g_meta_reg;
            q_sum_reg      <= SUM_W'(sqx) + SUM_W'(sqy);
            s_meta_reg[0]  <= q_meta_reg;
            s_state_reg[0] <= s_next[0];
            for (int s = 1; s < SQ_STAGES; s++)
            begin
                s_meta_reg[s]  <= s_meta_reg[s-1];
                s_state_reg[s] <= s_next[s];
            end
            out_meta_reg <= s_meta_reg[SQ_STAGES-1];
            out_norm_reg <= (|root_fin[ROOT_W-1:GRAD_W]) ? {GRAD_W{1'b1}}
                                                         : root_fin[GRAD_W-1:0];
        end
    end

    // Drive the result channel from the output register
    assign results.valid      = out_valid_reg;
    assign results.grad_x     = out_meta_reg.gx;
    assign results.grad_y     = out_meta_reg.gy;
    assign results.grad_norm  = out_norm_reg;
    assign results.centre_row = out_meta_reg.centre_row;
    assign results.centre_col = out_meta_reg.centre_col;
    assign results.last       = out_meta_reg.last;

endmodule

// ===== rtl/core/sobel_gradient_magnitude.sv =====
// ----------------------------------------------------------------------------
// Sobel gradient magnitude - top level
// 3x3 Sobel edge responses and magnitude over a raster grey pixel stream.
// ----------------------------------------------------------------------------
// One pixel is taken every clock cycle for as long as results are taken, the
// rate being set by the line store, which does one read and one write per
// cycle. Border centres give no result; every interior centre gives one
// result, passing the second front stage, the queue and the back-end stages.
// After reset the line store is swept to zero, during which no pixel is
// taken (configuration writes are). A short queue between the window logic
// and the arithmetic absorbs stalls on the result side.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude #(
    parameter int MAX_WIDTH   = sgm_pkg::MAX_WIDTH_DEF,
    parameter int QUEUE_DEPTH = sgm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    sgm_cfg_if.sink      cfg,
    sgm_pixel_if.sink    pixels,
    sgm_result_if.source results
);
    import sgm_pkg::*;

    logic      push;
    logic      pop;
    win_item_t push_item;
    win_item_t head;
    q_stat_t   q_stat;

    // Position, line stores and window
    sgm_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pixels    (pixels),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    // Decoupling queue
    sgm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    // Arithmetic and output register
    sgm_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .stat    (q_stat),
        .pop     (pop),
        .results (results)
    );

endmodule

// ===== rtl/core/sgm_checker.sv =====
// ----------------------------------------------------------------------------
// Sobel gradient magnitude - port checker
// Watches the result channel for stall behaviour, norm consistency and centre row.
// ----------------------------------------------------------------------------
`include "sobel_gradient_magnitude_macros.svh"

module sgm_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      res_valid,
    input logic                      res_ready,
    input logic [sgm_pkg::GRAD_W-1:0] grad_x,
    input logic [sgm_pkg::GRAD_W-1:0] grad_y,
    input logic [sgm_pkg::GRAD_W-1:0] grad_norm,
    input logic [sgm_pkg::ROW_W-1:0]  centre_row,
    input logic [sgm_pkg::CCOL_W-1:0] centre_col,
    input logic                      last
);
    import sgm_pkg::*;

    // A stalled result stays and holds its payload
    `SGM_ASSERT_NEXT(a_result_hold, res_valid && !res_ready, res_valid && $stable({grad_x, grad_y, grad_norm, centre_row, centre_col, last}), "result changed while stalled")

    // The norm is never below either response
    `SGM_ASSERT_SAME(a_norm_low, res_valid, grad_norm >= grad_x && grad_norm >= grad_y, "norm below a response")

    // The norm never exceeds the sum of the responses
    `SGM_ASSERT_SAME(a_norm_high, res_valid, {1'b0, grad_norm} <= {1'b0, grad_x} + {1'b0, grad_y}, "norm above sum of responses")

    // Interior centres are never on the top row
    `SGM_ASSERT_SAME(a_centre_row, res_valid, centre_row != '0, "result centred on the top row")

endmodule

bind sobel_gradient_magnitude sgm_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (results.valid),
    .res_ready  (results.ready),
    .grad_x     (results.grad_x),
    .grad_y     (results.grad_y),
    .grad_norm  (results.grad_norm),
    .centre_row (results.centre_row),
    .centre_col (results.centre_col),
    .last       (results.last)
);
